### src/cabs_pkg.sv
// ----------------------------------------------------------------------------
// cabs_pkg - shared constants and functions of the caustic alpha shader
// Request kinds, reciprocal constants for the scroll offsets, the fraction
// tables that complete the constant divisions, and the alpha ramp.
// ----------------------------------------------------------------------------
`default_nettype none

package cabs_pkg;

  // Request kind carried on tuser
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_SHADE = 1'b1;

  // Stream widths (whole bytes)
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 24;

  // Texture store: four banks split by row and column parity
  localparam int NUM_BANKS   = 4;
  localparam int BANK_DEPTH  = 16384;
  localparam int BANK_AW     = 14;

  // Reciprocals for 16-bit operands: x/5 = (x*MAGIC5)>>18, x/3 = (x*MAGIC3)>>17
  localparam logic [15:0] MAGIC5 = 16'hCCCD;
  localparam logic [15:0] MAGIC3 = 16'hAAAB;

  // Reciprocal for 8-bit operands: x/3 = (x*DIV3_MAGIC)>>9
  localparam logic [15:0] DIV3_MAGIC = 16'd171;

  // floor(r * 32768 / 5) for remainder r of a division by five
  function automatic logic [15:0] frac5(input logic [2:0] r);
    logic [15:0] f;
    begin
      unique case (r)
        3'd0:    f = 16'd0;
        3'd1:    f = 16'd6553;
        3'd2:    f = 16'd13107;
        3'd3:    f = 16'd19660;
        3'd4:    f = 16'd26214;
        default: f = 16'd0;
      endcase
      return f;
    end
  endfunction

  // floor(r * 32768 / 3) for remainder r of a division by three
  function automatic logic [15:0] frac3(input logic [1:0] r);
    logic [15:0] f;
    begin
      unique case (r)
        2'd0:    f = 16'd0;
        2'd1:    f = 16'd10922;
        2'd2:    f = 16'd21845;
        default: f = 16'd0;
      endcase
      return f;
    end
  endfunction

  // Alpha ramp: zero below 128, rising by five per step, falling from 160
  function automatic logic [7:0] ramp(input logic [7:0] a);
    logic [9:0] t;
    begin
      if (a >= 8'd160) begin
        t = 10'd575 - {1'b0, a, 1'b0};
      end else if (a >= 8'd128) begin
        t = 10'(({2'b00, a} - 10'd128) * 10'd5);
      end else begin
        t = 10'd0;
      end
      return t[7:0];
    end
  endfunction

endpackage

`default_nettype wire

### src/caustic_alpha_bilinear_shader.sv
// ----------------------------------------------------------------------------
// caustic_alpha_bilinear_shader - caustic alpha from a bilinear texture
// Holds a 256x256 grayscale texture in four parity banks, samples it twice
// per pixel with wrapping bilinear filtering and maps the mean to an alpha.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests arrive on in_t*. in_tuser selects the kind: a load writes
//   one texel into the texture store, a shade names a pixel and a frame
//   count. Loads produce no result; a shade outside the image is dropped.
//   Each shade yields one result on out_t* (alpha, echoed x and y).
//   Throughput is one request per cycle unless the receiver stalls. The
//   texture sits in four banks chosen by row and column parity, each with
//   two read ports, so the eight texels of both 2x2 footprints are fetched
//   together in the fourth stage; loads write the store in that same stage,
//   so every access lands in request order.
//   Each request moves through the numbered stages, then the output register.
//   Reset clears only the pipeline valid bits; the texture is undefined
//   until written and must be loaded before any shade reads it.
//   When the receiver stalls, stages fill up behind the output register;
//   in_tready falls only once every stage holds a live request.
// ----------------------------------------------------------------------------
`default_nettype none

module caustic_alpha_bilinear_shader #(
  parameter int IMAGE_WIDTH  = 128,
  parameter int IMAGE_HEIGHT = 64
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // Input request channel
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // [15:0] texel_addr, [23:16] texel_value, [30:24] pixel_x,
  // [36:31] pixel_y, [52:37] frame_count, [55:53] zero
  input  wire logic [cabs_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [0] mode
  input  wire logic                               in_tuser,
  // Result channel
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // [6:0] alpha_out, [13:7] out_x, [19:14] out_y, [23:20] zero
  output logic [cabs_pkg::OUT_TDATA_W-1:0]        out_tdata
);

  // Field unpack
  logic [15:0] in_addr;
  logic [7:0]  in_val;
  logic [6:0]  in_px;
  logic [5:0]  in_py;
  logic [15:0] in_fc;
  logic        in_inside;

  assign in_addr = in_tdata[15:0];
  assign in_val  = in_tdata[23:16];
  assign in_px   = in_tdata[30:24];
  assign in_py   = in_tdata[36:31];
  assign in_fc   = in_tdata[52:37];
  assign in_inside = ({2'b00, in_px} < 9'(IMAGE_WIDTH)) &&
                     ({3'b000, in_py} < 9'(IMAGE_HEIGHT));

  // Stage handshakes
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7, rdy_out;
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, s6_v_r, s7_v_r, out_valid_r;

  always_comb begin
    rdy_out = !out_valid_r || out_tready;
    rdy7    = !s7_v_r || rdy_out;
    rdy6    = !s6_v_r || rdy7;
    rdy5    = !s5_v_r || rdy6;
    rdy4    = !s4_v_r || rdy5;
    rdy3    = !s3_v_r || rdy4;
    rdy2    = !s2_v_r || rdy3;
    rdy1    = !s1_v_r || rdy2;
  end

  assign in_tready  = rdy1;
  assign out_tvalid = out_valid_r;

  // Stage 1: register request, start reciprocal multiplies
  logic        s1_mode_r;
  logic [15:0] s1_addr_r;
  logic [7:0]  s1_val_r;
  logic [6:0]  s1_px_r;
  logic [5:0]  s1_py_r;
  logic [15:0] s1_fc_r;
  logic [15:0] s1_fc1_r;
  logic [13:0] s1_q5_r;
  logic [14:0] s1_q3_r;
  logic [15:0] in_fc1;
  logic [31:0] q5_prod;
  logic [31:0] q3_prod;

  assign in_fc1  = in_fc + 16'd1;
  assign q5_prod = 32'(in_fc) * 32'(cabs_pkg::MAGIC5);
  assign q3_prod = 32'(in_fc1) * 32'(cabs_pkg::MAGIC3);

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_mode_r <= in_tuser;
      s1_addr_r <= in_addr;
      s1_val_r  <= in_val;
      s1_px_r   <= in_px;
      s1_py_r   <= in_py;
      s1_fc_r   <= in_fc;
      s1_fc1_r  <= in_fc1;
      s1_q5_r   <= q5_prod[31:18];
      s1_q3_r   <= q3_prod[31:17];
    end
  end

  // Stage 2: finish the divisions by ten and six (scroll offsets)
  logic        s2_mode_r;
  logic [15:0] s2_addr_r;
  logic [7:0]  s2_val_r;
  logic [6:0]  s2_px_r;
  logic [5:0]  s2_py_r;
  logic [15:0] s2_fc_r;
  logic [23:0] s2_d10_r;
  logic [23:0] s2_d6_r;
  logic [15:0] q5x5;
  logic [15:0] q3x3;
  logic [15:0] rem5;
  logic [15:0] rem3;
  logic [23:0] d10;
  logic [23:0] d6;

  always_comb begin
    q5x5 = {s1_q5_r, 2'b00} + {2'b00, s1_q5_r};
    q3x3 = {s1_q3_r, 1'b0} + {1'b0, s1_q3_r};
    rem5 = s1_fc_r - q5x5;
    rem3 = s1_fc1_r - q3x3;
    d10  = {s1_q5_r[8:0], 15'd0} + {8'd0, cabs_pkg::frac5(rem5[2:0])};
    d6   = {s1_q3_r[8:0], 15'd0} + {8'd0, cabs_pkg::frac3(rem3[1:0])};
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_mode_r <= s1_mode_r;
      s2_addr_r <= s1_addr_r;
      s2_val_r  <= s1_val_r;
      s2_px_r   <= s1_px_r;
      s2_py_r   <= s1_py_r;
      s2_fc_r   <= s1_fc_r;
      s2_d10_r  <= d10;
      s2_d6_r   <= d6;
    end
  end

  // Stage 3: texture coordinates, low 24 bits (8.16) of each
  logic        s3_mode_r;
  logic [15:0] s3_addr_r;
  logic [7:0]  s3_val_r;
  logic [6:0]  s3_px_r;
  logic [5:0]  s3_py_r;
  logic [23:0] s3_u_r [2];
  logic [23:0] s3_tv_r [2];
  logic [23:0] cu;
  logic [23:0] cv0;

  assign cu  = {s2_px_r, 17'd0};
  assign cv0 = {1'b0, s2_py_r, 17'd0};

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_mode_r  <= s2_mode_r;
      s3_addr_r  <= s2_addr_r;
      s3_val_r   <= s2_val_r;
      s3_px_r    <= s2_px_r;
      s3_py_r    <= s2_py_r;
      s3_u_r[0]  <= cu + s2_d10_r;
      s3_tv_r[0] <= cv0;
      s3_u_r[1]  <= cu - s2_d6_r;
      s3_tv_r[1] <= {s2_fc_r[10:0], 13'd0} - cv0;
    end
  end

  // Stage 4: texture access (bank reads or load write) and weight products
  logic [cabs_pkg::BANK_AW-1:0] rd_addr [2][cabs_pkg::NUM_BANKS];
  wire  [7:0]                   tex_rd  [2][cabs_pkg::NUM_BANKS];
  logic [6:0]  row_half [2][2];
  logic [6:0]  col_half [2][2];
  logic [15:0] wu [2][2];
  logic [15:0] wv [2][2];
  logic [31:0] wprod [2][4];
  logic        wr_en;
  logic [1:0]  wr_bank;
  logic [cabs_pkg::BANK_AW-1:0] wr_entry;

  // Bank {p,q} holds rows of parity p and columns of parity q
  always_comb begin
    for (int s = 0; s < 2; s++) begin
      for (int p = 0; p < 2; p++) begin
        row_half[s][p] = s3_tv_r[s][23:17] + 7'(s3_tv_r[s][16] & (p == 0));
        col_half[s][p] = s3_u_r[s][23:17] + 7'(s3_u_r[s][16] & (p == 0));
      end
      for (int b = 0; b < cabs_pkg::NUM_BANKS; b++) begin
        rd_addr[s][b] = {row_half[s][b / 2], col_half[s][b % 2]};
      end
    end
  end

  // Near weight is the complement of the odd far weight
  always_comb begin
    for (int s = 0; s < 2; s++) begin
      wu[s][1] = {s3_u_r[s][15:1], 1'b1};
      wu[s][0] = {~s3_u_r[s][15:1], 1'b1};
      wv[s][1] = {s3_tv_r[s][15:1], 1'b1};
      wv[s][0] = {~s3_tv_r[s][15:1], 1'b1};
      for (int k = 0; k < 4; k++) begin
        wprod[s][k] = 32'(wu[s][k % 2]) * 32'(wv[s][k / 2]);
      end
    end
  end

  assign wr_en    = rdy4 && s3_v_r && (s3_mode_r == cabs_pkg::MODE_LOAD);
  assign wr_bank  = {s3_addr_r[8], s3_addr_r[0]};
  assign wr_entry = {s3_addr_r[15:9], s3_addr_r[7:1]};

  for (genvar b = 0; b < cabs_pkg::NUM_BANKS; b++) begin : g_bank
    logic [7:0] mem [cabs_pkg::BANK_DEPTH];
    logic [7:0] rd0_r;
    logic [7:0] rd1_r;

    // Write one texel, read one texel per sample
    always_ff @(posedge clk) begin
      if (wr_en && (wr_bank == 2'(b))) begin
        mem[wr_entry] <= s3_val_r;
      end
      if (rdy4) begin
        rd0_r <= mem[rd_addr[0][b]];
        rd1_r <= mem[rd_addr[1][b]];
      end
    end

    assign tex_rd[0][b] = rd0_r;
    assign tex_rd[1][b] = rd1_r;
  end

  logic [6:0]  s4_px_r;
  logic [5:0]  s4_py_r;
  logic [15:0] s4_w_r [2][4];
  logic        s4_rp_r [2];
  logic        s4_cp_r [2];

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_px_r <= s3_px_r;
      s4_py_r <= s3_py_r;
      for (int s = 0; s < 2; s++) begin
        s4_rp_r[s] <= s3_tv_r[s][16];
        s4_cp_r[s] <= s3_u_r[s][16];
        for (int k = 0; k < 4; k++) begin
          s4_w_r[s][k] <= wprod[s][k][31:16];
        end
      end
    end
  end

  // Stage 5: route bank data back to footprint corners, weight each texel
  logic [6:0]  s5_px_r;
  logic [5:0]  s5_py_r;
  logic [7:0]  s5_term_r [2][4];
  logic [7:0]  corner [2][4];
  logic [23:0] tprod [2][4];
  logic [1:0]  corner_bank [2][4];

  always_comb begin
    for (int s = 0; s < 2; s++) begin
      for (int k = 0; k < 4; k++) begin
        corner_bank[s][k] = {s4_rp_r[s] ^ (k >= 2), s4_cp_r[s] ^ ((k % 2) == 1)};
        corner[s][k]      = tex_rd[s][corner_bank[s][k]];
        tprod[s][k]       = 24'(s4_w_r[s][k]) * 24'(corner[s][k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      s5_px_r <= s4_px_r;
      s5_py_r <= s4_py_r;
      for (int s = 0; s < 2; s++) begin
        for (int k = 0; k < 4; k++) begin
          s5_term_r[s][k] <= tprod[s][k][23:16];
        end
      end
    end
  end

  // Stage 6: sum each sample, average the pair
  logic [6:0] s6_px_r;
  logic [5:0] s6_py_r;
  logic [7:0] s6_avg_r;
  logic [9:0] samp_sum [2];
  logic [8:0] pair_sum;

  always_comb begin
    for (int s = 0; s < 2; s++) begin
      samp_sum[s] = 10'(s5_term_r[s][0]) + 10'(s5_term_r[s][1]) +
                    10'(s5_term_r[s][2]) + 10'(s5_term_r[s][3]);
    end
    pair_sum = {1'b0, samp_sum[0][7:0]} + {1'b0, samp_sum[1][7:0]};
  end

  always_ff @(posedge clk) begin
    if (rdy6) begin
      s6_px_r  <= s5_px_r;
      s6_py_r  <= s5_py_r;
      s6_avg_r <= pair_sum[8:1];
    end
  end

  // Stage 7: alpha ramp
  logic [6:0] s7_px_r;
  logic [5:0] s7_py_r;
  logic [7:0] s7_ramp_r;

  always_ff @(posedge clk) begin
    if (rdy7) begin
      s7_px_r   <= s6_px_r;
      s7_py_r   <= s6_py_r;
      s7_ramp_r <= cabs_pkg::ramp(s6_avg_r);
    end
  end

  // Output register: ramp divided by three
  logic [6:0]  out_alpha_r;
  logic [6:0]  out_x_r;
  logic [5:0]  out_y_r;
  logic [15:0] div3_prod;

  assign div3_prod = {8'd0, s7_ramp_r} * cabs_pkg::DIV3_MAGIC;

  always_ff @(posedge clk) begin
    if (rdy_out) begin
      out_alpha_r <= div3_prod[15:9];
      out_x_r     <= s7_px_r;
      out_y_r     <= s7_py_r;
    end
  end

  assign out_tdata = {4'd0, out_y_r, out_x_r, out_alpha_r};

  // Advance valid bits; drop loads after the store stage, drop outside pixels
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      s5_v_r      <= 1'b0;
      s6_v_r      <= 1'b0;
      s7_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) begin
        s1_v_r <= in_tvalid && ((in_tuser == cabs_pkg::MODE_LOAD) || in_inside);
      end
      if (rdy2) begin
        s2_v_r <= s1_v_r;
      end
      if (rdy3) begin
        s3_v_r <= s2_v_r;
      end
      if (rdy4) begin
        s4_v_r <= s3_v_r && (s3_mode_r == cabs_pkg::MODE_SHADE);
      end
      if (rdy5) begin
        s5_v_r <= s4_v_r;
      end
      if (rdy6) begin
        s6_v_r <= s5_v_r;
      end
      if (rdy7) begin
        s7_v_r <= s6_v_r;
      end
      if (rdy_out) begin
        out_valid_r <= s7_v_r;
      end
    end
  end

endmodule

`default_nettype wire
